// ----- rtl/mhs_pkg.sv -----
// ----------------------------------------------------------------------------
// mhs_pkg
// Shared constants, types and modular arithmetic for the shingle signature.
// ----------------------------------------------------------------------------
package mhs_pkg;

  localparam int unsigned WindowWords = 5;
  localparam int unsigned NumHashes   = 16;
  localparam int unsigned WinW        = $clog2(WindowWords + 1);
  localparam int unsigned HashW       = 4;

  localparam logic [60:0] ModQ = 61'h1FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] KindText = 2'd0;
  localparam logic [1:0] KindLoad = 2'd1;
  localparam logic [1:0] KindEnd  = 2'd2;

  localparam logic CfgWordMult    = 1'b0;
  localparam logic CfgShingleMult = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StWordMul,
    StWordAdd,
    StShMul,
    StShAdd,
    StSigRd,
    StSigMul,
    StSigAdd,
    StSigWr,
    StOutRd,
    StOutHold
  } state_e;

  typedef struct packed {
    logic        start;
    logic [60:0] a;
    logic [60:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [60:0] p;
  } mul_rsp_t;

  function automatic logic [60:0] fold61(input logic [63:0] s);
    logic [62:0] t;
    t = 63'(s[60:0]) + 63'(s[63:61]);
    if (t[61] || (t[60:0] == ModQ)) begin
      t = t - 63'(ModQ);
    end
    return t[60:0];
  endfunction

  function automatic logic [60:0] addmod(input logic [60:0] a, input logic [60:0] b);
    return fold61(64'(a) + 64'(b));
  endfunction

endpackage

// ----- rtl/mhs_mulmod.sv -----
// ----------------------------------------------------------------------------
// mhs_mulmod
// Multi-cycle (a*b) mod 2^61-1 using four partial products of 32-bit and 29-bit halves.
// ----------------------------------------------------------------------------
module mhs_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mhs_pkg::mul_req_t req_i,
  output mhs_pkg::mul_rsp_t rsp_o
);

  logic [2:0]   step_q, step_d;
  logic [28:0]  a1_q, b1_q, a1_d, b1_d;
  logic [31:0]  a0_q, b0_q, a0_d, b0_d;
  logic [63:0]  pp_q, pp_d;
  logic [123:0] acc_q, acc_d;
  logic [60:0]  p_q, p_d;
  logic [63:0]  s;

  always_comb begin
    step_d = step_q;
    a0_d = a0_q; a1_d = a1_q; b0_d = b0_q; b1_d = b1_q;
    pp_d = pp_q; acc_d = acc_q; p_d = p_q;
    s = 64'(acc_q[60:0]) + 64'(acc_q[121:61]);
    case (step_q)
      3'd0: begin
        if (req_i.start) begin
          a0_d = req_i.a[31:0]; a1_d = req_i.a[60:32];
          b0_d = req_i.b[31:0]; b1_d = req_i.b[60:32];
          acc_d = '0;
          step_d = 3'd1;
        end
      end
      3'd1: begin pp_d = a0_q * b0_q; step_d = 3'd2; end
      3'd2: begin
        acc_d = acc_q + 124'(pp_q);
        pp_d = 64'(a1_q) * 64'(b0_q); step_d = 3'd3;
      end
      3'd3: begin
        acc_d = acc_q + (124'(pp_q) << 32);
        pp_d = 64'(a0_q) * 64'(b1_q); step_d = 3'd4;
      end
      3'd4: begin
        acc_d = acc_q + (124'(pp_q) << 32);
        pp_d = 64'(a1_q) * 64'(b1_q); step_d = 3'd5;
      end
      3'd5: begin acc_d = acc_q + (124'(pp_q) << 64); step_d = 3'd6; end
      3'd6: begin p_d = mhs_pkg::fold61(s); step_d = 3'd7; end
      default: step_d = 3'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 3'd0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a0_q <= a0_d; a1_q <= a1_d; b0_q <= b0_d; b1_q <= b1_d;
    pp_q <= pp_d; acc_q <= acc_d; p_q <= p_d;
  end

  assign rsp_o.done = (step_q == 3'd7);
  assign rsp_o.p    = p_q;

endmodule

// ----- rtl/minhash_word_shingle_signature_core.sv -----
// ----------------------------------------------------------------------------
// minhash_word_shingle_signature_core
// Word-shingle MinHash signature over a byte stream.
// ----------------------------------------------------------------------------
// Input requests (kind/char_code/hash_index/coef_*) use valid/ready. A text
// byte that extends a word goes through the one shared multi-cycle modular
// multiplier. A word end with a full window walks WindowWords shingle
// products, then a signature memory read state, then NumHashes products
// (multiply, add, compare and write back in the signature memory).
// Loads and skipped bytes are taken without leaving the idle state. End of
// document reads the signature memory one entry per request and emits
// NumHashes result requests, the last one flagged; each entry is rewritten
// to all ones as it is sent. Coefficient tables live in a second memory
// read ahead of each signature product. After reset the signature memory is
// swept to all ones, one entry a cycle, before input is taken; config
// writes are always taken. When the receiver stalls, the result register
// holds and no input is taken.
// ----------------------------------------------------------------------------
module minhash_word_shingle_signature_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [60:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  hash_index_i,
  input  logic [60:0] coef_mul_i,
  input  logic [60:0] coef_add_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  sig_index_o,
  output logic [63:0] sig_value_o,
  output logic        last_o
);

  localparam int unsigned HW = mhs_pkg::HashW;
  localparam int unsigned RW = $clog2(mhs_pkg::WindowWords);

  logic [63:0]  sig_mem [mhs_pkg::NumHashes];
  logic [121:0] coef_mem [mhs_pkg::NumHashes];
  logic [60:0]  ring_q [mhs_pkg::WindowWords];

  mhs_pkg::state_e state_q, state_d;
  logic [60:0] wmult_q, smult_q;
  logic [60:0] word_q, word_d, x_q, x_d, h_q, h_d;
  logic        in_word_q, in_word_d;
  logic [RW-1:0] head_q, head_d, idx_q, idx_d;
  logic [mhs_pkg::WinW-1:0] count_q, count_d;
  logic [HW:0] cnt_q, cnt_d;
  logic        clr_q, clr_d;
  logic [7:0]  ch_q, ch_d;
  logic        ring_we;
  logic        sig_we;
  logic [HW-1:0] sig_wa, sig_ra;
  logic [63:0] sig_wd, sig_rd_q;
  logic [121:0] coef_rd_q;
  logic        ov_q, ov_d;
  logic [63:0] oval_q, oval_d;
  logic [HW-1:0] oidx_q, oidx_d;
  logic        olast_q, olast_d;
  logic [7:0]  c;
  logic        ws, drop;
  mhs_pkg::mul_req_t mreq;
  mhs_pkg::mul_rsp_t mrsp;

  mhs_mulmod u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  assign c = (char_code_i >= 8'h41 && char_code_i <= 8'h5A) ? char_code_i + 8'h20
                                                            : char_code_i;
  assign ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  always_comb begin
    case (c)
      8'h2E, 8'h21, 8'h3F, 8'h3A, 8'h3B, 8'h2C, 8'h28, 8'h29,
      8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h27, 8'h22, 8'h2F, 8'h2D: drop = 1'b1;
      default: drop = 1'b0;
    endcase
  end

  assign in_ready_o = (state_q == mhs_pkg::StIdle) && !clr_q && !ov_q;

  always_comb begin
    state_d = state_q;
    word_d = word_q; x_d = x_q; h_d = h_q;
    in_word_d = in_word_q; head_d = head_q; idx_d = idx_q;
    count_d = count_q; cnt_d = cnt_q; clr_d = clr_q; ch_d = ch_q;
    ring_we = 1'b0;
    sig_we = 1'b0; sig_wa = cnt_q[HW-1:0]; sig_wd = '1;
    sig_ra = cnt_q[HW-1:0];
    mreq = '0;
    ov_d = ov_q; oval_d = oval_q; oidx_d = oidx_q; olast_d = olast_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      mhs_pkg::StIdle: begin
        if (clr_q) begin
          sig_we = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == (HW+1)'(mhs_pkg::NumHashes - 1)) begin
            clr_d = 1'b0;
            cnt_d = '0;
          end
        end else if (in_valid_i && in_ready_o) begin
          if (kind_i == mhs_pkg::KindText) begin
            if (ws) begin
              if (in_word_q) begin
                ring_we = 1'b1;
                head_d = (head_q == RW'(mhs_pkg::WindowWords - 1)) ? '0 : head_q + 1'b1;
                if (count_q != mhs_pkg::WinW'(mhs_pkg::WindowWords)) count_d = count_q + 1'b1;
                word_d = '0;
                in_word_d = 1'b0;
                if (count_q >= mhs_pkg::WinW'(mhs_pkg::WindowWords - 1)) begin
                  x_d = '0;
                  idx_d = head_d;
                  cnt_d = '0;
                  state_d = mhs_pkg::StShMul;
                end
              end
            end else if (!drop) begin
              in_word_d = 1'b1;
              ch_d = c;
              state_d = mhs_pkg::StWordMul;
            end
          end else if (kind_i == mhs_pkg::KindEnd) begin
            cnt_d = '0;
            state_d = mhs_pkg::StOutRd;
          end
        end
      end
      mhs_pkg::StWordMul: begin
        mreq.start = 1'b1;
        mreq.a = word_q;
        mreq.b = mhs_pkg::fold61(64'(wmult_q));
        state_d = mhs_pkg::StWordAdd;
      end
      mhs_pkg::StWordAdd: begin
        if (mrsp.done) begin
          word_d = mhs_pkg::addmod(mrsp.p, 61'(ch_q));
          state_d = mhs_pkg::StIdle;
        end
      end
      mhs_pkg::StShMul: begin
        mreq.start = 1'b1;
        mreq.a = x_q;
        mreq.b = mhs_pkg::fold61(64'(smult_q));
        state_d = mhs_pkg::StShAdd;
      end
      mhs_pkg::StShAdd: begin
        if (mrsp.done) begin
          x_d = mhs_pkg::addmod(mrsp.p, ring_q[idx_q]);
          idx_d = (idx_q == RW'(mhs_pkg::WindowWords - 1)) ? '0 : idx_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == (HW+1)'(mhs_pkg::WindowWords - 1)) begin
            cnt_d = '0;
            state_d = mhs_pkg::StSigRd;
          end else begin
            state_d = mhs_pkg::StShMul;
          end
        end
      end
      mhs_pkg::StSigRd: state_d = mhs_pkg::StSigMul;
      mhs_pkg::StSigMul: begin
        mreq.start = 1'b1;
        mreq.a = mhs_pkg::fold61(64'(coef_rd_q[121:61]));
        mreq.b = x_q;
        state_d = mhs_pkg::StSigAdd;
      end
      mhs_pkg::StSigAdd: begin
        if (mrsp.done) begin
          h_d = mhs_pkg::addmod(mrsp.p, mhs_pkg::fold61(64'(coef_rd_q[60:0])));
          state_d = mhs_pkg::StSigWr;
        end
      end
      mhs_pkg::StSigWr: begin
        if (64'(h_q) < sig_rd_q) begin
          sig_we = 1'b1;
          sig_wd = 64'(h_q);
        end
        cnt_d = cnt_q + 1'b1;
        sig_ra = cnt_d[HW-1:0];
        if (cnt_q == (HW+1)'(mhs_pkg::NumHashes - 1)) begin
          cnt_d = '0;
          state_d = mhs_pkg::StIdle;
        end else begin
          state_d = mhs_pkg::StSigMul;
        end
      end
      mhs_pkg::StOutRd: state_d = mhs_pkg::StOutHold;
      mhs_pkg::StOutHold: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          oval_d = sig_rd_q;
          oidx_d = cnt_q[HW-1:0];
          olast_d = (cnt_q == (HW+1)'(mhs_pkg::NumHashes - 1));
          sig_we = 1'b1;
          sig_wd = '1;
          cnt_d = cnt_q + 1'b1;
          if (olast_d) begin
            cnt_d = '0;
            word_d = '0; in_word_d = 1'b0; head_d = '0; count_d = '0;
            state_d = mhs_pkg::StIdle;
          end else begin
            state_d = mhs_pkg::StOutRd;
            sig_ra = cnt_d[HW-1:0];
          end
        end
      end
      default: state_d = mhs_pkg::StIdle;
    endcase
    if (state_q == mhs_pkg::StSigRd) sig_ra = cnt_q[HW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhs_pkg::StIdle;
      wmult_q <= 61'd31;
      smult_q <= 61'd37;
      word_q <= '0; in_word_q <= 1'b0;
      head_q <= '0; count_q <= '0; cnt_q <= '0; clr_q <= 1'b1;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      word_q <= word_d; in_word_q <= in_word_d;
      head_q <= head_d; count_q <= count_d; cnt_q <= cnt_d; clr_q <= clr_d;
      ov_q <= ov_d;
      if (cfg_we_i) begin
        if (cfg_index_i == mhs_pkg::CfgWordMult) wmult_q <= cfg_data_i;
        else smult_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; h_q <= h_d; idx_q <= idx_d; ch_q <= ch_d;
    oval_q <= oval_d; oidx_q <= oidx_d; olast_q <= olast_d;
    if (ring_we) ring_q[head_q] <= word_q;
    if (sig_we) sig_mem[sig_wa] <= sig_wd;
    sig_rd_q <= sig_mem[sig_ra];
    if (in_valid_i && in_ready_o && !clr_q && kind_i == mhs_pkg::KindLoad) begin
      coef_mem[hash_index_i] <= {coef_mul_i, coef_add_i};
    end
    coef_rd_q <= coef_mem[cnt_d[HW-1:0]];
  end

  assign out_valid_o = ov_q;
  assign sig_value_o = oval_q;
  assign sig_index_o = oidx_q;
  assign last_o      = olast_q;

endmodule
